/* rtl/core/jch_pkg.sv */
// jch_pkg: shared types, constants and microcode ROM for the jump consistent hash block.
// Used by jch_sequencer, jch_datapath and jump_consistent_hash. No dependencies.
`timescale 1ns / 1ps
package jch_pkg;

    localparam logic [63:0] LCG_MULT        = 64'd2862933555777941757;
    localparam int unsigned KEY_SHIFT       = 33;
    localparam int unsigned SCALE_SHIFT     = 31;
    localparam int unsigned COUNT_RESET_RAW = 8192;

    typedef logic [3:0] t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_LL,
        OP_MUL_HL,
        OP_MUL_LH,
        OP_ACC,
        OP_KEY,
        OP_DIV,
        OP_DONE
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_NEXT_GE,
        C_DIV_MORE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic next_ge;
        logic div_more;
    } t_status;

    localparam t_pc PC_WAIT  = 4'd0;
    localparam t_pc PC_TEST  = 4'd1;
    localparam t_pc PC_MUL0  = 4'd2;
    localparam t_pc PC_MUL1  = 4'd3;
    localparam t_pc PC_MUL2  = 4'd4;
    localparam t_pc PC_MUL3  = 4'd5;
    localparam t_pc PC_KEY   = 4'd6;
    localparam t_pc PC_DIV   = 4'd7;
    localparam t_pc PC_LOOP  = 4'd8;
    localparam t_pc PC_DONE  = 4'd9;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            PC_WAIT: w = '{op: OP_LOAD,   cond: C_NO_START, target: PC_WAIT};
            PC_TEST: w = '{op: OP_NOP,    cond: C_NEXT_GE,  target: PC_DONE};
            PC_MUL0: w = '{op: OP_MUL_LL, cond: C_NEVER,    target: PC_WAIT};
            PC_MUL1: w = '{op: OP_MUL_HL, cond: C_NEVER,    target: PC_WAIT};
            PC_MUL2: w = '{op: OP_MUL_LH, cond: C_NEVER,    target: PC_WAIT};
            PC_MUL3: w = '{op: OP_ACC,    cond: C_NEVER,    target: PC_WAIT};
            PC_KEY:  w = '{op: OP_KEY,    cond: C_NEVER,    target: PC_WAIT};
            PC_DIV:  w = '{op: OP_DIV,    cond: C_DIV_MORE, target: PC_DIV};
            PC_LOOP: w = '{op: OP_NOP,    cond: C_ALWAYS,   target: PC_TEST};
            PC_DONE: w = '{op: OP_DONE,   cond: C_ALWAYS,   target: PC_WAIT};
            default: w = '{op: OP_NOP,    cond: C_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/jch_sequencer.sv */
// jch_sequencer: step counter, microcode ROM lookup and conditional jumps.
// Depends on jch_pkg.
`timescale 1ns / 1ps
module jch_sequencer
    import jch_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_op     o_op,
    output logic    o_busy
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   take;

    assign uw = ucode(r_pc);

    always_comb begin
        case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_START: take = !i_start;
            C_NEXT_GE:  take = i_status.next_ge;
            C_DIV_MORE: take = i_status.div_more;
            default:    take = 1'b1;
        endcase
        n_pc = take ? uw.target : t_pc'(r_pc + 1'b1);
    end

    always_comb begin
        o_op = uw.op;
        if (uw.op == OP_LOAD && !i_start) begin
            o_op = OP_NOP;
        end
    end

    assign o_busy = (r_pc != PC_WAIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

/* rtl/core/jch_datapath.sv */
// jch_datapath: key register, shared 32x32 multiplier, bit-serial divider, result register.
// Depends on jch_pkg; driven one operation per cycle by jch_sequencer.
`timescale 1ns / 1ps
module jch_datapath
    import jch_pkg::*;
#(
    parameter int BUCKET_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_op                    i_op,
    input  logic [63:0]            i_hash_key,
    input  logic [BUCKET_BITS:0]   i_count,
    output t_status                o_status,
    output logic                   o_valid,
    output logic [BUCKET_BITS-1:0] o_bucket_index
);

    localparam int NW    = BUCKET_BITS + 1 + SCALE_SHIFT;
    localparam int CNT_W = $clog2(NW);

    logic [63:0]            r_key;
    logic [63:0]            r_prod;
    logic [63:0]            r_acc;
    logic [BUCKET_BITS:0]   r_cand;
    logic [NW-1:0]          r_next;
    logic [NW-1:0]          r_num;
    logic [31:0]            r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_valid;
    logic [BUCKET_BITS-1:0] r_bucket;

    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [63:0]          prod_w;
    logic [31:0]          divisor;
    logic [32:0]          rem_sh;
    logic [32:0]          rem_dif;
    logic                 ge;
    logic [BUCKET_BITS:0] cand_m1;

    assign mul_a  = (i_op == OP_MUL_HL) ? r_key[63:32] : r_key[31:0];
    assign mul_b  = (i_op == OP_MUL_LH) ? LCG_MULT[63:32] : LCG_MULT[31:0];
    assign prod_w = {32'b0, mul_a} * {32'b0, mul_b};

    // divisor = (key >> 33) + 1, up to 2^31
    assign divisor = {1'b0, r_key[63:KEY_SHIFT]} + 32'd1;
    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign rem_dif = rem_sh - {1'b0, divisor};
    assign ge      = (rem_sh >= {1'b0, divisor});
    assign cand_m1 = r_cand - 1'b1;

    assign o_status.next_ge  = (r_next >= {{(NW-BUCKET_BITS-1){1'b0}}, i_count});
    assign o_status.div_more = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_key  <= i_hash_key;
                r_next <= '0;
                r_cand <= '0;
            end
            OP_MUL_LL: begin
                r_cand <= r_next[BUCKET_BITS:0] + 1'b1;
                r_prod <= prod_w;
            end
            OP_MUL_HL: begin
                r_acc  <= r_prod;
                r_prod <= prod_w;
            end
            OP_MUL_LH: begin
                r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                r_prod       <= prod_w;
            end
            OP_ACC: begin
                r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
            end
            OP_KEY: begin
                r_key <= r_acc + 64'd1;
                r_num <= {r_cand, {SCALE_SHIFT{1'b0}}};
                r_rem <= '0;
                r_cnt <= CNT_W'(NW - 1);
            end
            OP_DIV: begin
                r_rem  <= ge ? rem_dif[31:0] : rem_sh[31:0];
                r_num  <= {r_num[NW-2:0], 1'b0};
                r_next <= {r_next[NW-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
            end
            OP_DONE: begin
                r_bucket <= cand_m1[BUCKET_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_op == OP_DONE);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_bucket_index = r_bucket;

endmodule

/* rtl/core/jump_consistent_hash.sv */
// jump_consistent_hash: top level, bucket count register plus sequencer and datapath.
// Depends on jch_pkg, jch_sequencer and jch_datapath.
`timescale 1ns / 1ps
// Usage:
//   Raise start with i_hash_key while busy is low; that edge takes the transaction.
//   busy stays high while the key is placed. The bucket appears on o_bucket_index
//   for exactly one cycle with o_valid high; the receiver cannot stall it.
//   Config: write i_cfg_bucket_count with i_cfg_valid while o_cfg_ready is high
//   (ready whenever not busy). Zero counts as one bucket, values above
//   2^BUCKET_BITS saturate to 2^BUCKET_BITS.
//   Each jump runs a test step, the 64-bit LCG step on the shared 32x32
//   multiplier, a key update, the BUCKET_BITS+32 bit restoring divider at one
//   quotient bit per cycle, and a loop step. About ln(bucket_count)+1 jumps
//   per key. One key at a time; a new start is taken in the cycle the result
//   is shown.
//   Reset: synchronous active low; bucket count returns to 8192 (capped at
//   2^BUCKET_BITS), sequencer returns to its wait step, no result pending.
module jump_consistent_hash
    import jch_pkg::*;
#(
    parameter int BUCKET_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [63:0]            i_hash_key,
    output logic                   o_valid,
    output logic [BUCKET_BITS-1:0] o_bucket_index,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [BUCKET_BITS:0]   i_cfg_bucket_count
);

    localparam longint unsigned MAX_COUNT = 64'd1 << BUCKET_BITS;
    localparam logic [BUCKET_BITS:0] COUNT_RESET =
        (64'(COUNT_RESET_RAW) > MAX_COUNT) ? (BUCKET_BITS+1)'(MAX_COUNT)
                                            : (BUCKET_BITS+1)'(COUNT_RESET_RAW);

    logic [BUCKET_BITS:0] r_count;
    logic [BUCKET_BITS:0] n_count;
    t_op                  op;
    t_status              status;

    always_comb begin
        if (i_cfg_bucket_count == '0) begin
            n_count = (BUCKET_BITS+1)'(1);
        end else if (i_cfg_bucket_count[BUCKET_BITS] && |i_cfg_bucket_count[BUCKET_BITS-1:0]) begin
            n_count = {1'b1, {BUCKET_BITS{1'b0}}};
        end else begin
            n_count = i_cfg_bucket_count;
        end
    end

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= n_count;
        end
    end

    jch_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_op     (op),
        .o_busy   (busy)
    );

    jch_datapath #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_hash_key     (i_hash_key),
        .i_count        (r_count),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_bucket_index (o_bucket_index)
    );

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer busy");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((BUCKET_BITS+1)'(o_bucket_index) < r_count))
        else $error("bucket index not below bucket count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (64'(r_count) <= MAX_COUNT))
        else $error("bucket count register out of range");

endmodule

/* sim/jump_consistent_hash_tb.sv */
// jump_consistent_hash_tb: self-checking bench for the jump consistent hash block.
// Needs jch_pkg and jump_consistent_hash; drives keys and bucket counts, checks every bucket.
`timescale 1ns / 1ps
module jump_consistent_hash_tb
    import jch_pkg::*;
();

    localparam int BUCKET_BITS = 16;
    localparam int NUM_DIR     = 21;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 84;

    typedef struct packed {
        logic        is_cfg;
        logic [16:0] count;
        logic [63:0] key;
        logic        known;
        logic [15:0] exp_bucket;
    } t_dir_row;

    // count-only rows reprogram the register, key rows either carry a typed-in bucket
    // or are checked against the predictor
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{1'b0, 17'd0,      64'h0000_0000_0000_0000, 1'b0, 16'd0},
        '{1'b0, 17'd0,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd0},
        '{1'b0, 17'd0,      64'h0000_0000_0000_0001, 1'b0, 16'd0},
        '{1'b0, 17'd0,      64'h8000_0000_0000_0000, 1'b0, 16'd0},
        '{1'b1, 17'd1,      64'h0,                   1'b0, 16'd0},
        '{1'b0, 17'd0,      64'h0000_0000_0000_0000, 1'b1, 16'd0},
        '{1'b0, 17'd0,      64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'd0},
        '{1'b1, 17'd0,      64'h0,                   1'b0, 16'd0},
        '{1'b0, 17'd0,      64'h0123_4567_89AB_CDEF, 1'b1, 16'd0},
        '{1'b0, 17'd0,      64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 16'd0},
        '{1'b1, 17'd65536,  64'h0,                   1'b0, 16'd0},
        '{1'b0, 17'd0,      64'h0000_0000_0000_0000, 1'b0, 16'd0},
        '{1'b0, 17'd0,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd0},
        '{1'b0, 17'd0,      64'hDEAD_BEEF_CAFE_F00D, 1'b0, 16'd0},
        '{1'b1, 17'd131071, 64'h0,                   1'b0, 16'd0},
        '{1'b0, 17'd0,      64'h0000_0000_0000_0000, 1'b0, 16'd0},
        '{1'b0, 17'd0,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd0},
        '{1'b1, 17'd2,      64'h0,                   1'b0, 16'd0},
        '{1'b0, 17'd0,      64'h0000_0000_0000_0000, 1'b0, 16'd0},
        '{1'b0, 17'd0,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'd0},
        '{1'b0, 17'd0,      64'h5555_5555_AAAA_AAAA, 1'b0, 16'd0}
    };

    localparam logic [16:0] PHASE_COUNTS [NUM_PHASES - 2] = '{
        17'd1, 17'd2, 17'd3, 17'd17, 17'd1000, 17'd8192,
        17'd65535, 17'd65536, 17'd131071, 17'd0
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [63:0]            i_hash_key;
    logic                   o_valid;
    logic [BUCKET_BITS-1:0] o_bucket_index;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [BUCKET_BITS:0]   i_cfg_bucket_count;

    logic        row_known;
    logic [15:0] row_exp;
    logic [16:0] bucket_count_q;
    logic [15:0] exp_fifo [16];
    int          exp_wr;
    int          exp_rd;
    int          err_count;
    bit          no_gap_mode;

    jump_consistent_hash #(
        .BUCKET_BITS(BUCKET_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_hash_key        (i_hash_key),
        .o_valid           (o_valid),
        .o_bucket_index    (o_bucket_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_bucket_count(i_cfg_bucket_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] jump_bucket_of(input logic [63:0] key,
                                                   input logic [16:0] count_reg);
        logic [63:0] n;
        logic [63:0] k;
        logic [63:0] cand1;
        logic [63:0] nxt;
        logic [63:0] divisor;
        k     = key;
        n     = 64'(count_reg);
        cand1 = '0;
        nxt   = '0;
        if (n == 0) begin
            n = 1;
        end
        if (n > (64'd1 << BUCKET_BITS)) begin
            n = 64'd1 << BUCKET_BITS;
        end
        while (nxt < n) begin
            cand1   = nxt + 1;
            k       = k * LCG_MULT + 64'd1;
            divisor = (k >> KEY_SHIFT) + 64'd1;
            nxt     = (cand1 << SCALE_SHIFT) / divisor;
        end
        return 16'(cand1 - 1);
    endfunction

    always @(posedge i_clk) begin : scoreboard
        logic [15:0] want;
        if (!i_rst_n) begin
            bucket_count_q = 17'(COUNT_RESET_RAW);
            exp_wr         = 0;
            exp_rd         = 0;
        end else begin
            if (o_valid === 1'b1) begin
                if (exp_wr == exp_rd) begin
                    err_count++;
                    $display("%0t unexpected bucket_index: expected none, actual %0d",
                             $time, o_bucket_index);
                end else begin
                    want = exp_fifo[exp_rd[3:0]];
                    exp_rd++;
                    if (o_bucket_index !== want) begin
                        err_count++;
                        $display("%0t bucket_index mismatch: expected %0d, actual %0d",
                                 $time, want, o_bucket_index);
                    end
                end
            end
            if (start && busy === 1'b0) begin
                exp_fifo[exp_wr[3:0]] = row_known ? row_exp
                                        : jump_bucket_of(i_hash_key, bucket_count_q);
                exp_wr++;
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                bucket_count_q = i_cfg_bucket_count;
            end
        end
    end

    task automatic wait_drained();
        while (exp_wr != exp_rd) begin
            @(negedge i_clk);
        end
    endtask

    // leaves start high after the transaction so back-to-back keys need no gap
    task automatic send_key(input logic [63:0] key, input logic known,
                            input logic [15:0] expv);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            no_gap_mode = !no_gap_mode;
        end
        gap = no_gap_mode ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      = 1'b1;
        i_hash_key = key;
        row_known  = known;
        row_exp    = expv;
        while (busy !== 1'b0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_count(input logic [16:0] value);
        start = 1'b0;
        wait_drained();
        i_cfg_valid        = 1'b1;
        i_cfg_bucket_count = value;
        while (o_cfg_ready !== 1'b1) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        #50ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] key;
        logic [16:0] count;
        err_count          = 0;
        no_gap_mode        = 1'b0;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_hash_key         = '0;
        i_cfg_valid        = 1'b0;
        i_cfg_bucket_count = '0;
        row_known          = 1'b0;
        row_exp            = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NUM_DIR; r++) begin
            if (DIR_ROWS[r].is_cfg) begin
                write_count(DIR_ROWS[r].count);
            end else begin
                send_key(DIR_ROWS[r].key, DIR_ROWS[r].known, DIR_ROWS[r].exp_bucket);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            count = (p < NUM_PHASES - 2) ? PHASE_COUNTS[p] : 17'($urandom_range(0, 131071));
            write_count(count);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 19))
                    0: key = '0;
                    1: key = '1;
                    2: key = 64'd1 << $urandom_range(0, 63);
                    3: key = ~(64'd1 << $urandom_range(0, 63));
                    default: key = {$urandom, $urandom};
                endcase
                send_key(key, 1'b0, 16'd0);
                if ($urandom_range(0, 99) == 0) begin
                    start = 1'b0;
                    wait_drained();
                end
            end
        end

        start = 1'b0;
        wait_drained();
        repeat (200) @(negedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
